>>> hdl/acar_pkg.sv
// Shared types, codes and constants for the ARP cache with request retry.
package acar_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int REQUESTS_DEF = 16;

  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_QUEUE   = 3'd2;
  localparam logic [2:0] OP_REMREQ  = 3'd3;
  localparam logic [2:0] OP_REMENT  = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;

  localparam logic [1:0] KIND_ANSWER = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_GIVEUP = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SENDS   = 1'b1;

  localparam logic [7:0] TIMEOUT_RST = 8'd30;
  localparam logic [3:0] SENDS_RST   = 4'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic        found;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        full;
    logic        last;
  } result_t;

endpackage

>>> hdl/arp_cache_aging_retry.sv
// Top level: ARP cache and pending-request list walked by one sequencer.
//
//  channel | handshake        | payload
//  in      | valid / ready    | opcode, ip_address, mac_address
//  out     | out_valid/ready  | kind, found, ip_out, mac_out, full_res, last
//  cfg     | cfg_valid/ready  | cfg_index, cfg_data
//
// Each item walks one table (a tick walks both) slot by slot through the table
// memories, reading each slot in a read state and then comparing or writing it
// in an evaluate state.
// Removal compacts in place by copying each kept slot down to a write index.
// Reset empties both tables by clearing their counts; no clearing pass.
// A full output register stalls a tick's request walk and the final result until it is taken.
module arp_cache_aging_retry #(
  parameter int ENTRIES  = acar_pkg::ENTRIES_DEF,
  parameter int REQUESTS = acar_pkg::REQUESTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] ip_address,
  input  logic [47:0] mac_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        found,
  output logic [31:0] ip_out,
  output logic [47:0] mac_out,
  output logic        full_res,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import acar_pkg::*;

  localparam int EAW = $clog2(ENTRIES);
  localparam int RAW = $clog2(REQUESTS);
  localparam int ECW = $clog2(ENTRIES + 1);
  localparam int RCW = $clog2(REQUESTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERD   = 4'd1;
  localparam logic [3:0] S_EEV   = 4'd2;
  localparam logic [3:0] S_RRD   = 4'd3;
  localparam logic [3:0] S_REV   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;

  logic [3:0]  state;
  logic [2:0]  op;
  logic [31:0] ip;
  logic [47:0] mac;
  logic [7:0]  entry_timeout;
  logic [3:0]  max_sends;
  logic [ECW-1:0] entry_count, e_rd, e_wr;
  logic [RCW-1:0] request_count, r_rd, r_wr;
  logic        hit;
  logic [47:0] hit_mac;

  // entry memories
  logic           e_we;
  logic [EAW-1:0] e_waddr;
  logic [31:0]    e_wip, e_rip;
  logic [47:0]    e_wmac, e_rmac;
  logic [7:0]     e_wage, e_rage;
  // request memories
  logic           r_we;
  logic [RAW-1:0] r_waddr;
  logic [31:0]    r_wip, r_rip;
  logic [3:0]     r_wsends, r_rsends;
  logic [7:0]     r_wage, r_rage;

  acar_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_eip (.clk, .we(e_we), .waddr(e_waddr),
    .wdata(e_wip), .raddr(e_rd[EAW-1:0]), .rdata(e_rip));
  acar_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_emac (.clk, .we(e_we), .waddr(e_waddr),
    .wdata(e_wmac), .raddr(e_rd[EAW-1:0]), .rdata(e_rmac));
  acar_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_eage (.clk, .we(e_we), .waddr(e_waddr),
    .wdata(e_wage), .raddr(e_rd[EAW-1:0]), .rdata(e_rage));
  acar_ram #(.WIDTH(32), .DEPTH(REQUESTS)) u_rip (.clk, .we(r_we), .waddr(r_waddr),
    .wdata(r_wip), .raddr(r_rd[RAW-1:0]), .rdata(r_rip));
  acar_ram #(.WIDTH(4), .DEPTH(REQUESTS)) u_rsends (.clk, .we(r_we), .waddr(r_waddr),
    .wdata(r_wsends), .raddr(r_rd[RAW-1:0]), .rdata(r_rsends));
  acar_ram #(.WIDTH(8), .DEPTH(REQUESTS)) u_rage (.clk, .we(r_we), .waddr(r_waddr),
    .wdata(r_wage), .raddr(r_rd[RAW-1:0]), .rdata(r_rage));

  logic    ob_busy, ob_load;
  result_t ob_din, ob_dout;

  acar_outreg u_out (.clk, .rst, .load(ob_load), .din(ob_din), .busy(ob_busy),
    .valid(out_valid), .ready(out_ready), .dout(ob_dout));

  assign kind     = ob_dout.kind;
  assign found    = ob_dout.found;
  assign ip_out   = ob_dout.ip;
  assign mac_out  = ob_dout.mac;
  assign full_res = ob_dout.full;
  assign last     = ob_dout.last;

  assign ready     = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // walk decisions on the slot just read
  logic [7:0] e_age_inc, r_age_inc;
  logic       e_keep, e_match, r_match, r_skip, r_give, r_keep;
  logic       e_walk, r_walk;

  assign e_age_inc = (e_rage == 8'hFF) ? e_rage : e_rage + 8'd1;
  assign r_age_inc = (r_rage == 8'hFF) ? r_rage : r_rage + 8'd1;
  assign e_match   = (e_rip == ip);
  assign r_match   = (r_rip == ip);
  assign r_skip    = (r_age_inc <= 8'd1);
  assign r_give    = !r_skip && (r_rsends >= max_sends);
  assign e_keep    = (op == OP_TICK) ? (e_age_inc <= entry_timeout) : !e_match;
  assign r_keep    = (op == OP_TICK) ? !r_give : !r_match;
  assign e_walk    = (e_rd < entry_count);
  assign r_walk    = (r_rd < request_count);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = e_wr[EAW-1:0];
    e_wip   = e_rip;
    e_wmac  = e_rmac;
    e_wage  = (op == OP_TICK) ? e_age_inc : e_rage;
    r_we    = 1'b0;
    r_waddr = r_wr[RAW-1:0];
    r_wip   = r_rip;
    r_wsends = r_rsends;
    r_wage  = (op == OP_TICK) ? r_age_inc : r_rage;
    ob_load = 1'b0;
    ob_din  = '{kind: KIND_ANSWER, found: 1'b0, ip: ip, mac: 48'd0,
                full: 1'b0, last: 1'b1};
    case (state)
      S_EEV: begin
        if (op != OP_LOOKUP && e_keep) begin
          e_we = 1'b1;
        end
      end
      S_REV: begin
        if (op == OP_TICK && !r_skip && !ob_busy) begin
          ob_load     = 1'b1;
          ob_din.kind = r_give ? KIND_GIVEUP : KIND_SEND;
          ob_din.ip   = r_rip;
          ob_din.last = 1'b0;
        end
        if (op == OP_TICK && !r_skip && !r_give) begin
          r_wsends = (r_rsends == 4'hF) ? r_rsends : r_rsends + 4'd1;
          r_wage   = 8'd0;
        end
        if ((op == OP_TICK && !(ob_busy && !r_skip)) || op == OP_REMREQ) begin
          r_we = r_keep;
        end
      end
      S_FIN: begin
        if (!ob_busy) begin
          ob_load = 1'b1;
          case (op)
            OP_LOOKUP: begin
              ob_din.found = hit;
              ob_din.mac   = hit ? hit_mac : 48'd0;
            end
            OP_INSERT: begin
              ob_din.found = hit;
              ob_din.full  = (entry_count == ECW'(ENTRIES));
              e_we         = (entry_count != ECW'(ENTRIES));
              e_waddr      = entry_count[EAW-1:0];
              e_wip        = ip;
              e_wmac       = mac;
              e_wage       = 8'd0;
            end
            OP_QUEUE: begin
              ob_din.found = hit;
              ob_din.full  = !hit && (request_count == RCW'(REQUESTS));
              r_we         = !hit && (request_count != RCW'(REQUESTS));
              r_waddr      = request_count[RAW-1:0];
              r_wip        = ip;
              r_wsends     = 4'd0;
              r_wage       = 8'd0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      request_count <= '0;
      entry_timeout <= TIMEOUT_RST;
      max_sends     <= SENDS_RST;
      e_rd          <= '0;
      e_wr          <= '0;
      r_rd          <= '0;
      r_wr          <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_TIMEOUT) begin
              entry_timeout <= cfg_data;
            end else begin
              max_sends <= cfg_data[3:0];
            end
          end
          if (valid) begin
            op   <= opcode;
            ip   <= ip_address;
            mac  <= mac_address;
            hit  <= 1'b0;
            e_rd <= '0;
            e_wr <= '0;
            r_rd <= '0;
            r_wr <= '0;
            case (opcode)
              OP_LOOKUP, OP_REMENT, OP_TICK: state <= S_ERD;
              OP_INSERT, OP_QUEUE, OP_REMREQ: state <= S_RRD;
              OP_CLEAR: begin
                entry_count   <= '0;
                request_count <= '0;
                state         <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_ERD: begin
          if (e_walk && !(op == OP_LOOKUP && hit)) begin
            state <= S_EEV;
          end else begin
            if (op != OP_LOOKUP) begin
              entry_count <= e_wr;
            end
            state <= (op == OP_TICK) ? S_RRD : S_FIN;
          end
        end
        S_EEV: begin
          e_rd <= e_rd + 1'b1;
          if (op == OP_LOOKUP) begin
            if (e_match) begin
              hit     <= 1'b1;
              hit_mac <= e_rmac;
            end
          end else if (e_keep) begin
            e_wr <= e_wr + 1'b1;
          end
          state <= S_ERD;
        end
        S_RRD: begin
          if (r_walk && !((op == OP_INSERT || op == OP_QUEUE) && hit)) begin
            state <= S_REV;
          end else begin
            if (op == OP_TICK || op == OP_REMREQ) begin
              request_count <= r_wr;
            end
            state <= S_FIN;
          end
        end
        S_REV: begin
          if (!(op == OP_TICK && ob_busy && !r_skip)) begin
            r_rd <= r_rd + 1'b1;
            if (op == OP_INSERT || op == OP_QUEUE) begin
              if (r_match) begin
                hit <= 1'b1;
              end
            end else if (r_keep) begin
              r_wr <= r_wr + 1'b1;
            end
            state <= S_RRD;
          end
        end
        S_FIN: begin
          if (!ob_busy) begin
            if (op == OP_INSERT && entry_count != ECW'(ENTRIES)) begin
              entry_count <= entry_count + 1'b1;
            end
            if (op == OP_QUEUE && !hit && request_count != RCW'(REQUESTS)) begin
              request_count <= request_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_e: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ECW'(ENTRIES)) else $error("entry count overflow");
  a_cnt_r: assert property (@(posedge clk) disable iff (rst)
    request_count <= RCW'(REQUESTS)) else $error("request count overflow");
  a_wr_le_rd: assert property (@(posedge clk) disable iff (rst)
    e_wr <= e_rd && r_wr <= r_rd) else $error("compaction index ahead of walk");
  a_last: assert property (@(posedge clk) disable iff (rst)
    ob_load && state != S_FIN |-> !ob_din.last) else $error("early last result");

endmodule

>>> hdl/acar_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module acar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/acar_outreg.sv
// Output register holding one result until the consumer takes it.
module acar_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  acar_pkg::result_t din,
  output logic             busy,
  output logic             valid,
  input  logic             ready,
  output acar_pkg::result_t dout
);
  import acar_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      dout <= din;
    end
  end

  assign busy = valid && !ready;

endmodule

>>> sim/arp_cache_aging_retry_tb.sv
// Testbench for the ARP cache with request retry: directed table, then random traffic.
`timescale 1ns / 1ps

module arp_cache_aging_retry_tb;
  import acar_pkg::*;

  localparam int NENT = ENTRIES_DEF;
  localparam int NREQ = REQUESTS_DEF;
  localparam int LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [2:0]  opcode = OP_LOOKUP;
  logic [31:0] ip_address = '0;
  logic [47:0] mac_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        found;
  logic [31:0] ip_out;
  logic [47:0] mac_out;
  logic        full_res;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TIMEOUT;
  logic [7:0]  cfg_data = '0;

  arp_cache_aging_retry u_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [31:0] c_ip [NENT];
  logic [47:0] c_mac [NENT];
  logic [7:0]  c_age [NENT];
  int          c_cnt;
  logic [31:0] r_ip [NREQ];
  logic [3:0]  r_sends [NREQ];
  logic [7:0]  r_age [NREQ];
  int          r_cnt;
  logic [7:0]  timeout_q;
  logic [3:0]  sends_q;

  result_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_sends = 0;
  int n_giveups = 0;
  bit calm = 1'b0;

  function automatic result_t mk(logic [1:0] k, logic f, logic [31:0] a, logic [47:0] m,
                                 logic fl, logic l);
    result_t r;
    r.kind = k; r.found = f; r.ip = a; r.mac = m; r.full = fl; r.last = l;
    return r;
  endfunction

  function automatic void queue_expected(result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic bit pending(logic [31:0] a);
    for (int i = 0; i < r_cnt; i++) if (r_ip[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void drop_cache(int i);
    for (int j = i; j + 1 < c_cnt; j++) begin
      c_ip[j] = c_ip[j+1]; c_mac[j] = c_mac[j+1]; c_age[j] = c_age[j+1];
    end
    c_cnt--;
  endfunction

  function automatic void drop_req(int i);
    for (int j = i; j + 1 < r_cnt; j++) begin
      r_ip[j] = r_ip[j+1]; r_sends[j] = r_sends[j+1]; r_age[j] = r_age[j+1];
    end
    r_cnt--;
  endfunction

  function automatic void predict_arp(logic [2:0] op, logic [31:0] a, logic [47:0] m);
    int i;
    bit hit;
    logic [47:0] hm;
    case (op)
      OP_LOOKUP: begin
        hit = 1'b0; hm = '0;
        for (i = 0; i < c_cnt; i++) if (!hit && c_ip[i] == a) begin
          hit = 1'b1; hm = c_mac[i];
        end
        queue_expected(mk(KIND_ANSWER, hit, a, hm, 1'b0, 1'b1));
        return;
      end
      OP_INSERT: begin
        hit = 1'b1;
        if (c_cnt < NENT) begin
          c_ip[c_cnt] = a; c_mac[c_cnt] = m; c_age[c_cnt] = '0; c_cnt++; hit = 1'b0;
        end
        queue_expected(mk(KIND_ANSWER, pending(a), a, '0, hit, 1'b1));
        return;
      end
      OP_QUEUE: begin
        if (pending(a)) queue_expected(mk(KIND_ANSWER, 1'b1, a, '0, 1'b0, 1'b1));
        else if (r_cnt < NREQ) begin
          r_ip[r_cnt] = a; r_sends[r_cnt] = '0; r_age[r_cnt] = '0; r_cnt++;
          queue_expected(mk(KIND_ANSWER, 1'b0, a, '0, 1'b0, 1'b1));
        end else queue_expected(mk(KIND_ANSWER, 1'b0, a, '0, 1'b1, 1'b1));
        return;
      end
      OP_REMREQ: begin
        i = 0;
        while (i < r_cnt) if (r_ip[i] == a) drop_req(i); else i++;
      end
      OP_REMENT: begin
        i = 0;
        while (i < c_cnt) if (c_ip[i] == a) drop_cache(i); else i++;
      end
      OP_CLEAR: begin
        c_cnt = 0; r_cnt = 0;
      end
      OP_TICK: begin
        i = 0;
        while (i < c_cnt) begin
          if (c_age[i] != 8'hFF) c_age[i]++;
          if (c_age[i] > timeout_q) drop_cache(i); else i++;
        end
        i = 0;
        while (i < r_cnt) begin
          if (r_age[i] != 8'hFF) r_age[i]++;
          if (r_age[i] <= 8'd1) i++;
          else if (r_sends[i] >= sends_q) begin
            queue_expected(mk(KIND_GIVEUP, 1'b0, r_ip[i], '0, 1'b0, 1'b0));
            drop_req(i);
          end else begin
            queue_expected(mk(KIND_SEND, 1'b0, r_ip[i], '0, 1'b0, 1'b0));
            if (r_sends[i] != 4'hF) r_sends[i]++;
            r_age[i] = '0;
            i++;
          end
        end
      end
      default: ;
    endcase
    queue_expected(mk(KIND_ANSWER, 1'b0, a, '0, 1'b0, 1'b1));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
  endtask

  // result checker and output stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      result_t w;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected, ip_out", 64'(ip_out), 64'd0);
      end else begin
        w = expected_results.pop_front();
        if (kind !== w.kind) report_mismatch("kind", 64'(kind), 64'(w.kind));
        if (found !== w.found) report_mismatch("found", 64'(found), 64'(w.found));
        if (ip_out !== w.ip) report_mismatch("ip_out", 64'(ip_out), 64'(w.ip));
        if (mac_out !== w.mac) report_mismatch("mac_out", 64'(mac_out), 64'(w.mac));
        if (full_res !== w.full) report_mismatch("full_res", 64'(full_res), 64'(w.full));
        if (last !== w.last) report_mismatch("last", 64'(last), 64'(w.last));
        if (w.kind == KIND_SEND) n_sends++;
        if (w.kind == KIND_GIVEUP) n_giveups++;
      end
      n_results++;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (calm || rst) out_ready <= !rst;
      else if (stall > 0) begin
        stall--; out_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1; out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    @(posedge clk);
    while (cycles < LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("arp_cache_aging_retry_tb: done, errors");
    $finish;
  end

  task automatic send_cmd(logic [2:0] op, logic [31:0] a, logic [47:0] m);
    if (!calm && $urandom_range(0, 4) == 0) begin
      valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    valid <= 1'b1; opcode <= op; ip_address <= a; mac_address <= m;
    do @(posedge clk); while (!ready);
    predict_arp(op, a, m);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] d);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TIMEOUT) timeout_q = d; else sends_q = d[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [47:0] m;
    bit          chk;
    logic        efound;
    logic [47:0] emac;
  } cmd_t;

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 3) == 0) return {$urandom()};
    return 32'h0A00_0000 | $urandom_range(0, 11);
  endfunction

  initial begin
    cmd_t dir [$];
    logic [2:0] op;
    int k;
    c_cnt = 0; r_cnt = 0; timeout_q = TIMEOUT_RST; sends_q = SENDS_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    dir = '{
      '{OP_LOOKUP, 32'h0, 48'h0, 1'b1, 1'b0, 48'h0},
      '{OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{OP_INSERT, 32'h0, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0, 1'b0, 48'h0},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{OP_QUEUE, 32'hC0A8_0001, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_QUEUE, 32'hC0A8_0001, 48'h0, 1'b1, 1'b1, 48'h0},
      '{OP_INSERT, 32'hC0A8_0001, 48'hAAAA_5555_AAAA, 1'b0, 1'b0, 48'h0},
      '{OP_QUEUE, 32'hC0A8_0002, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_TICK, 32'h0, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_TICK, 32'h0, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_TICK, 32'h0, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_REMREQ, 32'hC0A8_0002, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_REMENT, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, 1'b0, 48'h0},
      '{3'd7, 32'h5555_AAAA, 48'h5555_5555_5555, 1'b1, 1'b0, 48'h0},
      '{OP_CLEAR, 32'h0, 48'h0, 1'b0, 1'b0, 48'h0},
      '{OP_LOOKUP, 32'h0, 48'h0, 1'b1, 1'b0, 48'h0}
    };
    foreach (dir[i]) begin
      send_cmd(dir[i].op, dir[i].a, dir[i].m);
      if (dir[i].chk)
        expected_results[expected_results.size() - 1] =
          mk(KIND_ANSWER, dir[i].efound, dir[i].a, dir[i].emac, 1'b0, 1'b1);
    end
    // fill both tables past capacity
    for (int i = 0; i < NENT + 2; i++) send_cmd(OP_INSERT, 32'h0B00_0000 + i, {$urandom(), 16'h0});
    for (int i = 0; i < NREQ + 2; i++) send_cmd(OP_QUEUE, 32'h0C00_0000 + i, 48'h0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_TIMEOUT, 8'd0); write_cfg(CFG_SENDS, 8'd0); end
        1: begin write_cfg(CFG_TIMEOUT, 8'd255); write_cfg(CFG_SENDS, 8'd15); end
        2: begin write_cfg(CFG_TIMEOUT, 8'd1); write_cfg(CFG_SENDS, 8'd1); end
        3: begin write_cfg(CFG_TIMEOUT, 8'd3); write_cfg(CFG_SENDS, 8'd2); end
        4: begin
          write_cfg(CFG_TIMEOUT, 8'($urandom_range(1, 255)));
          write_cfg(CFG_SENDS, 8'($urandom_range(0, 15)));
        end
        default: begin write_cfg(CFG_TIMEOUT, 8'd30); write_cfg(CFG_SENDS, 8'd5); calm = 1'b1; end
      endcase
      for (int n = 0; n < 70; n++) begin
        k = $urandom_range(0, 99);
        if (k < 20) op = OP_LOOKUP;
        else if (k < 38) op = OP_INSERT;
        else if (k < 56) op = OP_QUEUE;
        else if (k < 62) op = OP_REMREQ;
        else if (k < 68) op = OP_REMENT;
        else if (k < 70) op = OP_CLEAR;
        else if (k < 98) op = OP_TICK;
        else op = 3'd7;
        send_cmd(op, pick_ip(), {$urandom(), 16'($urandom())});
      end
      wait_idle();
    end

    $display("covered %0d commands, %0d results (%0d resends, %0d give-ups)",
             n_items, n_results, n_sends, n_giveups);
    if (errors == 0) $display("arp_cache_aging_retry_tb: done, clean");
    else $display("arp_cache_aging_retry_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hdl/acar_pkg.sv
hdl/acar_ram.sv
hdl/acar_outreg.sv
hdl/arp_cache_aging_retry.sv
sim/arp_cache_aging_retry_tb.sv
